@@ design/cbs_pkg.sv @@
// Shared constants, types and helpers of the conveyor block sorter.
package cbs_pkg;

    localparam int PENDING_SLOTS = 4;
    localparam int TIMER_BITS    = 16;
    localparam int COUNT_BITS    = 8;
    localparam int FIRE_BITS     = $clog2(PENDING_SLOTS + 1);
    localparam int MISS_BITS     = COUNT_BITS + 2;
    localparam int DELAY_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int IN_TDATA_W    = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE_DELAY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_DELAY  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHECK_DELAY = 2'd2;

    localparam logic [DELAY_BITS-1:0] CLOSE_DELAY_RST = 16'd90;
    localparam logic [DELAY_BITS-1:0] OPEN_DELAY_RST  = 16'd20;
    localparam logic [DELAY_BITS-1:0] CHECK_DELAY_RST = 16'd133;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    typedef struct packed {
        logic                 fire_any;
        logic [FIRE_BITS-1:0] fire_cnt;
        logic                 overflow;
    } slot_status_t;

    typedef struct packed {
        logic                 clear_large;
        logic                 clear_small;
        logic [1:0]           small_hit;
        logic [1:0]           large_hit;
        logic [FIRE_BITS-1:0] confirm0;
        logic [FIRE_BITS-1:0] confirm1;
    } tally_ctl_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] conf1;
        logic [COUNT_BITS-1:0] conf0;
        logic [COUNT_BITS-1:0] large1;
        logic [COUNT_BITS-1:0] large0;
        logic [COUNT_BITS-1:0] small1;
        logic [COUNT_BITS-1:0] small0;
    } counts_t;

    typedef struct packed {
        logic                 overflow;
        logic [MISS_BITS-1:0] missed;
        counts_t              counts;
        logic [1:0]           gate;
    } out_word_t;

    localparam int OUT_BITS    = $bits(out_word_t);
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Zero acts as one, too-wide values saturate.
    function automatic logic [TIMER_BITS-1:0] load_delay(input logic [DELAY_BITS-1:0] d);
        logic [32:0] dw;
        dw = 33'(d);
        if (dw == 33'd0) begin
            return TIMER_BITS'(1);
        end else if (dw > TIMER_MAX) begin
            return '1;
        end
        return TIMER_BITS'(dw);
    endfunction

endpackage

@@ design/conveyor_block_sorter_unit.sv @@
// Top level of the conveyor block sorter: tick decode, gate timer and output register.
// The result of an accepted input word reaches m_tdata in the next cycle. Throughput:
// one word per cycle unless m_tready stalls; all slot countdowns and counters update
// in parallel in the single logic stage between the state and output registers.
// Reset (aresetn low, synchronous): all slots idle, gates open, counters zero,
// delays back to 90/20/133, output empty.
module conveyor_block_sorter_unit import cbs_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // size_belt0[1:0], size_belt1[3:2], count_belt0[4], count_belt1[5],
    // clear_large[6], clear_small[7]
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // gate_code[1:0], small_seen0[9:2], small_seen1[17:10], large_seen0[25:18],
    // large_seen1[33:26], large_confirmed0[41:34], large_confirmed1[49:42],
    // missed_total[59:50], slot_overflow[60], zero fill above
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DELAY_BITS-1:0]   cfg_data
);

    logic [DELAY_BITS-1:0] close_delay_reg;
    logic [DELAY_BITS-1:0] open_delay_reg;
    logic [DELAY_BITS-1:0] check_delay_reg;

    logic [1:0]            last0_reg, last1_reg;
    logic [1:0]            gate_reg, gate_next;
    logic [TIMER_BITS-1:0] open_cd_reg, open_cd_next;
    logic                  open_act_reg, open_act_next;
    logic                  m_tvalid_reg;
    out_word_t             m_word_reg, word_next;

    logic       advance;
    logic [1:0] size0, size1;
    logic       cnt0, cnt1;
    logic [1:0] small_hit, large_hit;
    logic       open_fire;

    slot_status_t          close_st0, close_st1, check_st0, check_st1;
    tally_ctl_t            tally_ctl;
    counts_t               counts_next;
    logic [MISS_BITS-1:0]  missed_next;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign advance   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_TDATA_W'(m_word_reg);

    assign size0 = s_tdata[1:0];
    assign size1 = s_tdata[3:2];
    assign cnt0  = s_tdata[4];
    assign cnt1  = s_tdata[5];

    always_comb begin
        small_hit[0] = (size0 == 2'd0) && ((last0_reg == 2'd1) || (last0_reg == 2'd3));
        small_hit[1] = (size1 == 2'd0) && ((last1_reg == 2'd1) || (last1_reg == 2'd3));
        large_hit[0] = (size0 == 2'd3) && (last0_reg == 2'd1);
        large_hit[1] = (size1 == 2'd3) && (last1_reg == 2'd1);
    end

    cbs_slot_bank u_close0 (
        .aclk(aclk), .aresetn(aresetn), .advance(advance), .request(small_hit[0]),
        .delay(load_delay(close_delay_reg)), .status(close_st0)
    );
    cbs_slot_bank u_close1 (
        .aclk(aclk), .aresetn(aresetn), .advance(advance), .request(small_hit[1]),
        .delay(load_delay(close_delay_reg)), .status(close_st1)
    );
    cbs_slot_bank u_check0 (
        .aclk(aclk), .aresetn(aresetn), .advance(advance), .request(large_hit[0]),
        .delay(load_delay(check_delay_reg)), .status(check_st0)
    );
    cbs_slot_bank u_check1 (
        .aclk(aclk), .aresetn(aresetn), .advance(advance), .request(large_hit[1]),
        .delay(load_delay(check_delay_reg)), .status(check_st1)
    );

    always_comb begin
        tally_ctl.clear_large = s_tdata[6];
        tally_ctl.clear_small = s_tdata[7];
        tally_ctl.small_hit   = small_hit;
        tally_ctl.large_hit   = large_hit;
        tally_ctl.confirm0    = cnt0 ? check_st0.fire_cnt : '0;
        tally_ctl.confirm1    = cnt1 ? check_st1.fire_cnt : '0;
    end

    cbs_tally u_tally (
        .aclk(aclk), .aresetn(aresetn), .advance(advance), .ctl(tally_ctl),
        .counts_next(counts_next), .missed_next(missed_next)
    );

    // Open expiry first, then closes OR in and restart the shared timer.
    always_comb begin
        open_fire = open_act_reg && (open_cd_reg <= TIMER_BITS'(1));
        gate_next = open_fire ? 2'b00 : gate_reg;
        gate_next = gate_next | {close_st1.fire_any, close_st0.fire_any};
        if (close_st0.fire_any || close_st1.fire_any) begin
            open_act_next = 1'b1;
            open_cd_next  = load_delay(open_delay_reg);
        end else begin
            open_act_next = open_act_reg && !open_fire;
            open_cd_next  = open_act_reg ? open_cd_reg - TIMER_BITS'(1) : open_cd_reg;
        end
        word_next.gate     = gate_next;
        word_next.counts   = counts_next;
        word_next.missed   = missed_next;
        word_next.overflow = close_st0.overflow || close_st1.overflow
                          || check_st0.overflow || check_st1.overflow;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_delay_reg <= CLOSE_DELAY_RST;
            open_delay_reg  <= OPEN_DELAY_RST;
            check_delay_reg <= CHECK_DELAY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CLOSE_DELAY: close_delay_reg <= cfg_data;
                REG_OPEN_DELAY:  open_delay_reg  <= cfg_data;
                REG_CHECK_DELAY: check_delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last0_reg    <= 2'd0;
            last1_reg    <= 2'd0;
            gate_reg     <= 2'b00;
            open_act_reg <= 1'b0;
        end else if (advance) begin
            last0_reg    <= size0;
            last1_reg    <= size1;
            gate_reg     <= gate_next;
            open_act_reg <= open_act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            open_cd_reg <= open_cd_next;
            m_word_reg  <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("accepted word produced no result");

    a_gate_needs_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (gate_reg != 2'b00) |-> open_act_reg)
        else $error("gate closed without a running open timer");

    a_result_gate_match: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_word_reg.gate == gate_reg))
        else $error("result gate code differs from gate state");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid_reg)
        else $error("input stalled with an empty output register");

endmodule

@@ design/cbs_slot_bank.sv @@
// Pending-request slot bank: countdown per slot, fire detect and free-slot allocation.
module cbs_slot_bank import cbs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  request,
    input  logic [TIMER_BITS-1:0] delay,
    output slot_status_t          status
);

    logic [TIMER_BITS-1:0]    cd_reg  [PENDING_SLOTS];
    logic [TIMER_BITS-1:0]    cd_next [PENDING_SLOTS];
    logic [PENDING_SLOTS-1:0] act_reg;
    logic [PENDING_SLOTS-1:0] act_next;
    logic [PENDING_SLOTS-1:0] fire;
    logic [PENDING_SLOTS-1:0] act_left;
    logic [PENDING_SLOTS-1:0] pick;
    logic                     found;

    always_comb begin
        found = !request;
        for (int i = 0; i < PENDING_SLOTS; i++) begin
            fire[i]     = act_reg[i] && (cd_reg[i] <= TIMER_BITS'(1));
            act_left[i] = act_reg[i] && !fire[i];
        end
        for (int i = 0; i < PENDING_SLOTS; i++) begin
            pick[i] = 1'b0;
            if (!found && !act_left[i]) begin
                pick[i] = 1'b1;
                found   = 1'b1;
            end
        end
        for (int i = 0; i < PENDING_SLOTS; i++) begin
            if (pick[i]) begin
                cd_next[i] = delay;
            end else if (act_reg[i]) begin
                cd_next[i] = cd_reg[i] - TIMER_BITS'(1);
            end else begin
                cd_next[i] = cd_reg[i];
            end
        end
        act_next        = act_left | pick;
        status.fire_any = |fire;
        status.fire_cnt = FIRE_BITS'($countones(fire));
        status.overflow = request && (&act_left);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= '0;
        end else if (advance) begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < PENDING_SLOTS; i++) begin
                cd_reg[i] <= cd_next[i];
            end
        end
    end

endmodule

@@ design/cbs_tally.sv @@
// Block counters with clears, wrapping increments and the missed-block difference.
module cbs_tally import cbs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  tally_ctl_t           ctl,
    output counts_t              counts_next,
    output logic [MISS_BITS-1:0] missed_next
);

    counts_t counts_reg;
    counts_t base;

    always_comb begin
        base = counts_reg;
        if (ctl.clear_large) begin
            base.large0 = '0;
            base.large1 = '0;
            base.conf0  = '0;
            base.conf1  = '0;
        end
        if (ctl.clear_small) begin
            base.small0 = '0;
            base.small1 = '0;
        end
        counts_next.small0 = base.small0 + COUNT_BITS'(ctl.small_hit[0]);
        counts_next.small1 = base.small1 + COUNT_BITS'(ctl.small_hit[1]);
        counts_next.large0 = base.large0 + COUNT_BITS'(ctl.large_hit[0]);
        counts_next.large1 = base.large1 + COUNT_BITS'(ctl.large_hit[1]);
        counts_next.conf0  = base.conf0 + COUNT_BITS'(ctl.confirm0);
        counts_next.conf1  = base.conf1 + COUNT_BITS'(ctl.confirm1);
        missed_next = MISS_BITS'(counts_next.large0) + MISS_BITS'(counts_next.large1)
                    - MISS_BITS'(counts_next.conf0) - MISS_BITS'(counts_next.conf1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg <= '0;
        end else if (advance) begin
            counts_reg <= counts_next;
        end
    end

endmodule
